// File: sv/sdepcf_pkg.sv
`default_nettype none

package sdepcf_pkg;

    localparam int PLD_DEPTH  = 16;
    localparam int PLD_IDX_W  = 4;
    localparam int PLD_CNT_W  = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CMD_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 8'd1;

    localparam logic [15:0] CMD_ID_RST = 16'h0000;
    localparam logic [7:0]  HEADER_RST = 8'h10;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       msg_last;
    } t_msg;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       packet_end;
        logic       run_last;
    } t_res;

    typedef struct packed {
        logic [7:0]           msg_byte;
        logic                 flush;
        logic                 last;
        logic [PLD_IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [15:0] cmd_id;
        logic [7:0]  header;
    } t_frame_cfg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_CTL,
        BK_CTH,
        BK_SIZE,
        BK_DATA
    } t_bstate;

endpackage

`default_nettype wire

// File: sv/sdep_command_framer_core.sv
`default_nettype none
// Channel   Ports                                        Handshake
// msg in    push, full, i_msg                            push && !full
// result    empty, pop, o_res                            pop && !empty
// config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   valid && ready
// Bytes that only fill the store are written by the back end while it idles.
// A packet is four header beats (header, command id low, command id high,
// size) then its payload, one output beat per cycle while the result queue
// has room, paced by the back-end sequencer and its single store read port.
// Synchronous reset clears control state; the payload store is not cleared.
// A full result queue stalls the back end; the two-entry command queue then
// fills and raises full.

module sdep_command_framer_core #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire sdepcf_pkg::t_msg                     i_msg,
    output logic                                      empty,
    input  wire logic                                 pop,
    output sdepcf_pkg::t_res                          o_res,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [sdepcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sdepcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sdepcf_pkg::*;

    t_frame_cfg r_cfg;
    logic       cmd_valid, cmd_pop;
    t_cmd       cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_id <= CMD_ID_RST;
            r_cfg.header <= HEADER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CMD_ID: r_cfg.cmd_id <= i_cfg_data;
                CFG_HEADER: r_cfg.header <= i_cfg_data[7:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    sdepcf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_msg       (i_msg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    sdepcf_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// File: sv/sdepcf_front.sv
`default_nettype none

module sdepcf_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sdepcf_pkg::t_msg  i_msg,
    output logic                   o_cmd_valid,
    output sdepcf_pkg::t_cmd       o_cmd,
    input  wire logic              i_cmd_pop
);
    import sdepcf_pkg::*;

    logic [PLD_CNT_W-1:0] r_count, n_count;
    t_cmd                 r_q [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_fill;
    logic                 accept, pop_ok, flush;
    logic [PLD_IDX_W-1:0] idx;
    t_cmd                 cmd;

    assign full        = (r_fill == 2'd2);
    assign accept      = push && !full;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop_ok      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        flush        = (r_count == PLD_CNT_W'(MAX_PAYLOAD));
        idx          = flush ? '0 : r_count[PLD_IDX_W-1:0];
        cmd.msg_byte = i_msg.msg_byte;
        cmd.flush    = flush;
        cmd.last     = i_msg.msg_last;
        cmd.idx      = idx;
        n_count      = r_count;
        if (accept) begin
            if (i_msg.msg_last) begin
                n_count = '0;
            end else if (flush) begin
                n_count = PLD_CNT_W'(1);
            end else begin
                n_count = r_count + PLD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_fill  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            case ({accept, pop_ok})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/sdepcf_back.sv
`default_nettype none

module sdepcf_back #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sdepcf_pkg::t_frame_cfg i_cfg,
    input  wire logic                   i_cmd_valid,
    input  wire sdepcf_pkg::t_cmd       i_cmd,
    output logic                        o_cmd_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output sdepcf_pkg::t_res            o_res
);
    import sdepcf_pkg::*;

    t_bstate              r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic                 r_more, n_more;
    logic [PLD_CNT_W-1:0] r_len, n_len;
    logic [PLD_IDX_W-1:0] r_i, n_i;
    logic [7:0]           r_mem [PLD_DEPTH];
    logic [7:0]           r_rd;
    logic                 wr_en;
    logic [PLD_IDX_W-1:0] wr_idx, rd_idx;
    logic [7:0]           wr_byte;
    logic                 data_end;

    t_res                 r_oq [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_fill;
    logic                 oq_full, oq_push, oq_pop;
    t_res                 oq_data;

    assign oq_full  = (r_fill == 2'd2);
    assign empty    = (r_fill == 2'd0);
    assign oq_pop   = pop && !empty;
    assign o_res    = r_oq[r_rp];
    assign data_end = ({1'b0, r_i} + PLD_CNT_W'(1)) == r_len;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_more    = r_more;
        n_len     = r_len;
        n_i       = r_i;
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = r_cmd.idx;
        wr_byte   = r_cmd.msg_byte;
        oq_push   = 1'b0;
        oq_data   = '0;
        rd_idx    = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.flush) begin
                        n_more  = 1'b1;
                        n_len   = PLD_CNT_W'(MAX_PAYLOAD);
                        n_state = BK_HDR;
                    end else begin
                        wr_en   = 1'b1;
                        wr_idx  = i_cmd.idx;
                        wr_byte = i_cmd.msg_byte;
                        if (i_cmd.last) begin
                            n_more  = 1'b0;
                            n_len   = {1'b0, i_cmd.idx} + PLD_CNT_W'(1);
                            n_state = BK_HDR;
                        end
                    end
                end
            end
            BK_HDR: begin
                oq_data.spi_byte = i_cfg.header;
                if (!oq_full) begin
                    oq_push = 1'b1;
                    n_state = BK_CTL;
                end
            end
            BK_CTL: begin
                oq_data.spi_byte = i_cfg.cmd_id[7:0];
                if (!oq_full) begin
                    oq_push = 1'b1;
                    n_state = BK_CTH;
                end
            end
            BK_CTH: begin
                oq_data.spi_byte = i_cfg.cmd_id[15:8];
                if (!oq_full) begin
                    oq_push = 1'b1;
                    n_state = BK_SIZE;
                end
            end
            BK_SIZE: begin
                oq_data.spi_byte = {r_more, 2'b00, r_len};
                if (!oq_full) begin
                    oq_push = 1'b1;
                    n_i     = '0;
                    n_state = BK_DATA;
                end
            end
            BK_DATA: begin
                oq_data.spi_byte   = r_rd;
                oq_data.packet_end = data_end;
                oq_data.run_last   = data_end && !(r_more && r_cmd.last);
                rd_idx             = r_i;
                if (!oq_full) begin
                    oq_push = 1'b1;
                    if (data_end) begin
                        rd_idx = '0;
                        if (r_more) begin
                            wr_en = 1'b1;
                            if (r_cmd.last) begin
                                n_more  = 1'b0;
                                n_len   = {1'b0, r_cmd.idx} + PLD_CNT_W'(1);
                                n_state = BK_HDR;
                            end else begin
                                n_state = BK_IDLE;
                            end
                        end else begin
                            n_state = BK_IDLE;
                        end
                    end else begin
                        rd_idx = r_i + PLD_IDX_W'(1);
                        n_i    = r_i + PLD_IDX_W'(1);
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_more <= n_more;
        r_len  <= n_len;
        r_i    <= n_i;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_byte;
        end
        r_rd <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (oq_push) begin
                r_wp <= !r_wp;
            end
            if (oq_pop) begin
                r_rp <= !r_rp;
            end
            case ({oq_push, oq_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_wp] <= oq_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/sdepcf_chk.sv
`default_nettype none

module sdepcf_chk (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire sdepcf_pkg::t_res o_res
);
    import sdepcf_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    a_run_last_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.run_last) |-> o_res.packet_end)
        else $error("run_last beat is not a packet end");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_res))
        else $error("waiting result beat changed");

    a_known_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown(o_res))
        else $error("result beat has unknown bits");

endmodule

bind sdep_command_framer_core sdepcf_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
    import sdepcf_pkg::*;

    localparam int MAX_PLD   = 16;
    localparam int IDLE_WAIT = 5 + 2 * MAX_PLD + 8;
    localparam int LIMIT     = 1_000_000;
    localparam int RAND_ITEMS_PER_PHASE = 40;

    typedef struct {
        t_msg msg;
        int   gap;
        bit   drain_first;
    } t_pending;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_msg                  i_msg       = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_res                  o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_pending msg_q[$];
    t_res     frame_q[$];

    logic [7:0]           pld_buf [PLD_DEPTH];
    logic [PLD_CNT_W-1:0] pld_cnt = '0;
    logic [15:0]          cfg_cmd = CMD_ID_RST;
    logic [7:0]           cfg_hdr = HEADER_RST;

    t_res run_buf [64];
    int   run_n;

    int n_err      = 0;
    int n_in       = 0;
    int n_out      = 0;
    int n_pkt      = 0;
    int n_cfg      = 0;
    int cycles     = 0;
    int gap_left   = 0;
    int stall_left = 0;
    bit rx_fast    = 1'b0;

    sdep_command_framer_core #(
        .MAX_PAYLOAD(MAX_PLD)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_msg       (i_msg),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic put_beat(input logic [7:0] b, input logic pend);
        run_buf[run_n] = {b, pend, 1'b0};
        run_n++;
    endtask

    task automatic frame_packet(input int count, input bit more);
        logic [7:0] size;
        size = (count > MAX_PLD) ? 8'(MAX_PLD) : 8'(count);
        put_beat(cfg_hdr, 1'b0);
        put_beat(cfg_cmd[7:0], 1'b0);
        put_beat(cfg_cmd[15:8], 1'b0);
        put_beat(more ? (size | 8'h80) : size, size == 8'd0);
        for (int i = 0; i < int'(size); i++)
            put_beat(pld_buf[i % PLD_DEPTH], i + 1 == int'(size));
        n_pkt++;
    endtask

    task automatic frame_byte(input t_msg m);
        run_n = 0;
        if (pld_cnt >= MAX_PLD) begin
            frame_packet(MAX_PLD, 1'b1);
            pld_cnt = '0;
        end
        pld_buf[pld_cnt[PLD_IDX_W-1:0]] = m.msg_byte;
        pld_cnt = pld_cnt + 1'b1;
        if (m.msg_last) begin
            frame_packet(int'(pld_cnt), 1'b0);
            pld_cnt = '0;
        end
        for (int i = 0; i < run_n; i++) begin
            if (i == run_n - 1)
                run_buf[i].run_last = 1'b1;
            frame_q.push_back(run_buf[i]);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            n_err++;
            if (n_err <= 50)
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endtask

    // driver: one message beat per handshake, gap drawn per item
    always @(posedge i_clk) begin
        t_pending nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left = 0;
        end else if (!(push && full)) begin
            if (push) begin
                frame_byte(i_msg);
                n_in++;
            end
            if (gap_left > 0) begin
                push <= 1'b0;
                gap_left--;
            end else if (msg_q.size() > 0 && !(msg_q[0].drain_first && frame_q.size() > 0)) begin
                nxt = msg_q.pop_front();
                i_msg <= nxt.msg;
                push <= 1'b1;
                gap_left = nxt.gap;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest predicted beat
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
            rx_fast = 1'b0;
        end else begin
            if (pop && !empty) begin
                n_out++;
                if (frame_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 50)
                        $display("%0t: unexpected result beat, expected none actual %h",
                                 $time, o_res);
                end else begin
                    want = frame_q.pop_front();
                    check_field("spi_byte", want.spi_byte, o_res.spi_byte);
                    check_field("packet_end", 8'(want.packet_end), 8'(o_res.packet_end));
                    check_field("run_last", 8'(want.run_last), 8'(o_res.run_last));
                end
                if (o_res.run_last)
                    rx_fast = ($urandom_range(0, 3) == 0);
                stall_left = rx_fast ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d beats still expected", $time, frame_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input bit last, input bit fast,
                            input bit drain);
        t_pending p;
        p.msg.msg_byte = b;
        p.msg.msg_last = last;
        p.gap = fast ? 0 : $urandom_range(0, 15);
        p.drain_first = drain;
        msg_q.push_back(p);
    endtask

    task automatic add_msg(input int len, input bit fast);
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(0, 255)), i == len - 1, fast,
                     $urandom_range(0, 63) == 0);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return $urandom_range(1, 4);
        else if (r < 15)
            return $urandom_range(5, 15);
        else if (r < 18)
            return $urandom_range(16, 17);
        else if (r == 18)
            return $urandom_range(31, 33);
        return 48;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CMD_ID: cfg_cmd = data;
            CFG_HEADER: cfg_hdr = data[7:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic settle();
        do @(negedge i_clk); while (msg_q.size() > 0 || push || frame_q.size() > 0);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_phase();
        int count;
        int len;
        count = 0;
        while (count < RAND_ITEMS_PER_PHASE) begin
            len = pick_len();
            add_msg(len, $urandom_range(0, 3) == 0);
            count += len;
        end
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 32-byte message: full-buffer flush with more set, then exact-multiple close
        add_byte(8'h00, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 29; i++)
            add_byte(8'($urandom_range(0, 255)), 1'b0, i > 20, 1'b0);
        add_byte(8'h5A, 1'b1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        // hold off until every pending beat has drained
        add_byte(8'h00, 1'b1, 1'b0, 1'b1);
        settle();

        write_reg(CFG_CMD_ID, 16'hFFFF);
        write_reg(CFG_HEADER, 16'h00FF);
        random_phase();

        write_reg(CFG_CMD_ID, 16'h0000);
        write_reg(CFG_HEADER, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        random_phase();

        repeat (2) begin
            write_reg(CFG_CMD_ID, 16'($urandom_range(0, 65535)));
            write_reg(CFG_HEADER, 16'($urandom_range(0, 255)));
            random_phase();
        end

        $display("sent %0d message beats framed into %0d packets, checked %0d result beats",
                 n_in, n_pkt, n_out);
        $display("across %0d register writes, including extremes and an unmapped index",
                 n_cfg);
        if (n_err == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/sdepcf_pkg.sv
sv/sdepcf_front.sv
sv/sdepcf_back.sv
sv/sdep_command_framer_core.sv
sv/sdepcf_chk.sv
sim/tb.sv
